// ===== rtl/thc_pkg.sv =====
// ----------------------------------------------------------------------------
// thc_pkg: shared types, constants and helpers
// Register codes, calibration bundle, inter-module payload and the 32-bit
// arithmetic shift used throughout the compensation datapath.
// ----------------------------------------------------------------------------
package thc_pkg;

  // configuration register codes
  localparam logic [2:0] REG_CAL_T1    = 3'd0;
  localparam logic [2:0] REG_CAL_T2    = 3'd1;
  localparam logic [2:0] REG_CAL_T3    = 3'd2;
  localparam logic [2:0] REG_CAL_H1    = 3'd3;
  localparam logic [2:0] REG_CAL_H2    = 3'd4;
  localparam logic [2:0] REG_CAL_H3    = 3'd5;
  localparam logic [2:0] REG_CAL_H4_H5 = 3'd6;
  localparam logic [2:0] REG_CAL_H6    = 3'd7;

  localparam int CFG_W = 24;

  // datapath constants (32-bit words)
  localparam logic [31:0]        HUM_OFFSET   = 32'd76800;
  localparam logic signed [31:0] HUM_MAX      = 32'sd419430400;
  localparam logic [31:0]        HUM_ROUND    = 32'd16384;
  localparam logic [31:0]        HUM_BIAS     = 32'd2097152;
  localparam logic [31:0]        HUM_GAIN_RND = 32'd8192;
  localparam logic [31:0]        HUM_ONE      = 32'd32768;
  localparam logic [31:0]        TEMP_RND     = 32'd128;
  localparam logic signed [31:0] TEMP_MAX     = 32'sd32767;
  localparam logic signed [31:0] TEMP_MIN     = -32'sd32768;

  // calibration registers
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [23:0] h4_h5;
    logic [7:0]  h6;
  } cal_regs_t;

  // request handed from the temperature path to the humidity path
  typedef struct packed {
    logic [15:0] temp;      // saturated temperature, 0.01 degC
    logic [31:0] var_fine;  // fine term minus humidity offset
    logic [15:0] raw_hum;
  } thc_mid_t;

  // arithmetic right shift of a 32-bit two's-complement word
  function automatic logic [31:0] sar(input logic [31:0] x, input logic [4:0] sh);
    sar = 32'($signed(x) >>> sh);
  endfunction

endpackage

// ===== rtl/thc_temp_path.sv =====
// ----------------------------------------------------------------------------
// thc_temp_path: temperature compensation pipeline
// Four stages: two products, scaling, fine term, then temperature rounding,
// saturation and the humidity offset term.
// ----------------------------------------------------------------------------
module thc_temp_path (
  input  logic                clk,
  input  logic                rst_n,
  input  thc_pkg::cal_regs_t  cal,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [19:0]         in_raw_temp,
  input  logic [15:0]         in_raw_hum,
  output logic                out_valid,
  input  logic                out_ready,
  output thc_pkg::thc_mid_t   out_mid
);

  localparam int NS = 4;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // extended coefficients
  logic [31:0] t1_w, t2_w, t3_w;
  assign t1_w = {16'b0, cal.t1};
  assign t2_w = {{16{cal.t2[15]}}, cal.t2};
  assign t3_w = {{16{cal.t3[15]}}, cal.t3};

  // stage 1: linear and square products
  logic [31:0] lin_diff, sq_diff;
  logic [31:0] s1_p1_r, s1_dd_r;
  logic [15:0] s1_hum_r;
  assign lin_diff = {15'b0, in_raw_temp[19:3]} - {t1_w[30:0], 1'b0};
  assign sq_diff  = {16'b0, in_raw_temp[19:4]} - t1_w;

  // stage 2: scaling and third coefficient product
  logic [31:0] s2_a_r, s2_q_r;
  logic [15:0] s2_hum_r;

  // stage 3: fine term
  logic [31:0] s3_fine_r;
  logic [15:0] s3_hum_r;

  // stage 4: rounding, saturation, humidity offset
  logic [31:0]       tw;
  logic [15:0]       temp_sat;
  thc_pkg::thc_mid_t mid_r;
  assign tw = thc_pkg::sar({s3_fine_r[29:0], 2'b0} + s3_fine_r + thc_pkg::TEMP_RND, 5'd8);

  always_comb begin
    priority if ($signed(tw) > thc_pkg::TEMP_MAX) begin
      temp_sat = 16'h7fff;
    end else if ($signed(tw) < thc_pkg::TEMP_MIN) begin
      temp_sat = 16'h8000;
    end else begin
      temp_sat = tw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_p1_r  <= lin_diff * t2_w;
      s1_dd_r  <= sq_diff * sq_diff;
      s1_hum_r <= in_raw_hum;
    end
    if (rdy[1]) begin
      s2_a_r   <= thc_pkg::sar(s1_p1_r, 5'd11);
      s2_q_r   <= thc_pkg::sar(s1_dd_r, 5'd12) * t3_w;
      s2_hum_r <= s1_hum_r;
    end
    if (rdy[2]) begin
      s3_fine_r <= s2_a_r + thc_pkg::sar(s2_q_r, 5'd14);
      s3_hum_r  <= s2_hum_r;
    end
    if (rdy[3]) begin
      mid_r.temp     <= temp_sat;
      mid_r.var_fine <= s3_fine_r - thc_pkg::HUM_OFFSET;
      mid_r.raw_hum  <= s3_hum_r;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS-1];
  assign out_mid   = mid_r;

endmodule

// ===== rtl/thc_hum_path.sv =====
// ----------------------------------------------------------------------------
// thc_hum_path: humidity compensation pipeline
// Nine stages, each at most one multiply deep, ending in the clamp to
// 0..100 percent and the output register.
// ----------------------------------------------------------------------------
module thc_hum_path (
  input  logic                clk,
  input  logic                rst_n,
  input  thc_pkg::cal_regs_t  cal,
  input  logic                in_valid,
  output logic                in_ready,
  input  thc_pkg::thc_mid_t   in_mid,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_temp_centi,
  output logic [16:0]         out_hum_q10
);

  localparam int NS = 9;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  // backpressure chain
  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // extended coefficients
  logic [31:0] h1_w, h2_w, h3_w, h4_w, h5_w, h6_w;
  assign h1_w = {24'b0, cal.h1};
  assign h2_w = {{16{cal.h2[15]}}, cal.h2};
  assign h3_w = {24'b0, cal.h3};
  assign h4_w = {20'b0, cal.h4_h5[11:0]};
  assign h5_w = {20'b0, cal.h4_h5[23:12]};
  assign h6_w = {{24{cal.h6[7]}}, cal.h6};

  // temperature rides along to the end
  logic [15:0] temp_r [NS];

  // stage 1: products of the offset fine term
  logic [31:0] s1_h5v_r, s1_vh6_r, s1_vh3_r;
  logic [15:0] s1_hum_r;

  // stage 2: raw term and gain factors
  logic [31:0] raw_term;
  logic [31:0] s2_ah_r, s2_b1_r, s2_b2_r;
  assign raw_term = {2'b0, s1_hum_r, 14'b0} - {h4_w[11:0], 20'b0} - s1_h5v_r;

  // stage 3: gain product
  logic [31:0] s3_bm_r, s3_ah_r;

  // stage 4: bias and second gain coefficient
  logic [31:0] s4_bh_r, s4_ah_r;

  // stage 5: rounding of the gain
  logic [31:0] s5_bf_r, s5_ah_r;

  // stage 6: uncorrected humidity word
  logic [31:0] s6_vv_r;

  // stage 7: square of the scaled word
  logic [31:0] c_scaled;
  logic [31:0] s7_cc_r, s7_vv_r;
  assign c_scaled = thc_pkg::sar(s6_vv_r, 5'd15);

  // stage 8: quadratic correction weight
  logic [31:0] s8_c2_r, s8_vv_r;

  // stage 9: correction, clamp, output
  logic [31:0] hum_word;
  logic [16:0] hum_clamp;
  logic [16:0] hum_r;
  assign hum_word = s8_vv_r - thc_pkg::sar(s8_c2_r, 5'd4);

  always_comb begin
    priority if ($signed(hum_word) < 0) begin
      hum_clamp = '0;
    end else if ($signed(hum_word) > thc_pkg::HUM_MAX) begin
      hum_clamp = thc_pkg::HUM_MAX[28:12];
    end else begin
      hum_clamp = hum_word[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_h5v_r  <= h5_w * in_mid.var_fine;
      s1_vh6_r  <= in_mid.var_fine * h6_w;
      s1_vh3_r  <= in_mid.var_fine * h3_w;
      s1_hum_r  <= in_mid.raw_hum;
      temp_r[0] <= in_mid.temp;
    end
    if (rdy[1]) begin
      s2_ah_r <= thc_pkg::sar(raw_term + thc_pkg::HUM_ROUND, 5'd15);
      s2_b1_r <= thc_pkg::sar(s1_vh6_r, 5'd10);
      s2_b2_r <= thc_pkg::sar(s1_vh3_r, 5'd11) + thc_pkg::HUM_ONE;
    end
    if (rdy[2]) begin
      s3_bm_r <= s2_b1_r * s2_b2_r;
      s3_ah_r <= s2_ah_r;
    end
    if (rdy[3]) begin
      s4_bh_r <= (thc_pkg::sar(s3_bm_r, 5'd10) + thc_pkg::HUM_BIAS) * h2_w;
      s4_ah_r <= s3_ah_r;
    end
    if (rdy[4]) begin
      s5_bf_r <= thc_pkg::sar(s4_bh_r + thc_pkg::HUM_GAIN_RND, 5'd14);
      s5_ah_r <= s4_ah_r;
    end
    if (rdy[5]) begin
      s6_vv_r <= s5_ah_r * s5_bf_r;
    end
    if (rdy[6]) begin
      s7_cc_r <= c_scaled * c_scaled;
      s7_vv_r <= s6_vv_r;
    end
    if (rdy[7]) begin
      s8_c2_r <= thc_pkg::sar(s7_cc_r, 5'd7) * h1_w;
      s8_vv_r <= s7_vv_r;
    end
    if (rdy[8]) begin
      hum_r <= hum_clamp;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) temp_r[k] <= temp_r[k-1];
    end
  end

  assign in_ready       = rdy[0];
  assign out_valid      = vld_r[NS-1];
  assign out_temp_centi = $signed(temp_r[NS-1]);
  assign out_hum_q10    = hum_r;

endmodule

// ===== rtl/temp_humidity_compensation.sv =====
// ----------------------------------------------------------------------------
// temp_humidity_compensation: temperature and humidity compensation
// Raw temperature and humidity readings in, temperature in 0.01 degC and
// relative humidity in percent times 1024 out, from calibration registers.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  in_      | in        | valid / ready      | raw_temp[19:0], raw_hum[15:0]
//  out_     | out       | valid / ready      | temp_centi[15:0], hum_q10[16:0]
//  cfg_     | in        | write enable only  | addr[2:0], wdata[23:0]
//
// One request per cycle sustained while the output is not stalled; the 4-stage
// temperature pipeline feeds the 9-stage humidity pipeline, each stage
// at most one 32-bit multiply deep.
// Reset (synchronous, active low) empties the pipeline and clears all
// calibration registers.
// A stalled output holds every stage that is full; empty stages still fill,
// so in_ready only drops when all 13 stages hold requests.
// ----------------------------------------------------------------------------
module temp_humidity_compensation (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_addr,
  input  logic [thc_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [19:0]               in_raw_temp,
  input  logic [15:0]               in_raw_hum,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        out_temp_centi,
  output logic [16:0]               out_hum_q10
);

  // calibration registers
  thc_pkg::cal_regs_t cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        thc_pkg::REG_CAL_T1:    cal_r.t1    <= cfg_wdata[15:0];
        thc_pkg::REG_CAL_T2:    cal_r.t2    <= cfg_wdata[15:0];
        thc_pkg::REG_CAL_T3:    cal_r.t3    <= cfg_wdata[15:0];
        thc_pkg::REG_CAL_H1:    cal_r.h1    <= cfg_wdata[7:0];
        thc_pkg::REG_CAL_H2:    cal_r.h2    <= cfg_wdata[15:0];
        thc_pkg::REG_CAL_H3:    cal_r.h3    <= cfg_wdata[7:0];
        thc_pkg::REG_CAL_H4_H5: cal_r.h4_h5 <= cfg_wdata[23:0];
        thc_pkg::REG_CAL_H6:    cal_r.h6    <= cfg_wdata[7:0];
      endcase
    end
  end

  // temperature path -> humidity path
  logic              mid_valid;
  logic              mid_ready;
  thc_pkg::thc_mid_t mid;

  thc_temp_path u_temp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cal         (cal_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_raw_temp (in_raw_temp),
    .in_raw_hum  (in_raw_hum),
    .out_valid   (mid_valid),
    .out_ready   (mid_ready),
    .out_mid     (mid)
  );

  thc_hum_path u_hum (
    .clk            (clk),
    .rst_n          (rst_n),
    .cal            (cal_r),
    .in_valid       (mid_valid),
    .in_ready       (mid_ready),
    .in_mid         (mid),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_temp_centi (out_temp_centi),
    .out_hum_q10    (out_hum_q10)
  );

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output valid or input stalled after reset");

  // input only backs up when the output is stalled
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // humidity clamp holds
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hum_q10 <= 17'd102400)
    else $error("humidity above 100 percent");

endmodule
